/* hw/rtl/knot_pkg.sv */
// Shared types and constants for the KNOT permutation block.
// Used by the interfaces, the sequencer, the round unit and the top level.
// No dependencies.
package knot_pkg;

   localparam int unsigned ROW_W     = 128;
   localparam int unsigned HALF_W    = 64;
   localparam int unsigned RC_W      = 8;
   localparam int unsigned ROUND_W   = 8;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 8;
   localparam int unsigned VAR_W     = 3;

   // constant table lengths
   localparam logic [ROUND_W-1:0] LEN_RC6 = 8'd52;
   localparam logic [ROUND_W-1:0] LEN_RC7 = 8'd104;
   localparam logic [ROUND_W-1:0] LEN_RC8 = 8'd140;

   localparam logic [RC_W-1:0] RC_SEED = 8'h01;

   typedef logic [ROW_W-1:0] row_type;

   typedef enum logic [VAR_W-1:0] {
      VAR_256_RC6 = 3'd0,
      VAR_256_RC7 = 3'd1,
      VAR_384_RC7 = 3'd2,
      VAR_512_RC7 = 3'd3,
      VAR_512_RC8 = 3'd4
   } variant_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VARIANT = 2'd0,
      CSR_ROUNDS  = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } fsm_type;

   // sequencer -> datapath controls
   typedef struct packed {
      logic ready;
      logic load;
      logic step;
      logic rsp_valid;
   } ctrl_type;

   // valid bits of a row for the selected state width
   function automatic row_type row_mask(variant_type v);
      row_type m;
      m = '0;
      unique case (v)
         VAR_256_RC6, VAR_256_RC7: m = {{(ROW_W-64){1'b0}}, {64{1'b1}}};
         VAR_384_RC7:              m = {{(ROW_W-96){1'b0}}, {96{1'b1}}};
         default:                  m = {ROW_W{1'b1}};
      endcase
      return m;
   endfunction

endpackage

/* hw/rtl/knot_if.sv */
// Request and response channel interfaces for the KNOT permutation block.
// Depends on knot_pkg for the half-row width.
interface knot_req_if import knot_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] row0_lo;
   logic [HALF_W-1:0] row0_hi;
   logic [HALF_W-1:0] row1_lo;
   logic [HALF_W-1:0] row1_hi;
   logic [HALF_W-1:0] row2_lo;
   logic [HALF_W-1:0] row2_hi;
   logic [HALF_W-1:0] row3_lo;
   logic [HALF_W-1:0] row3_hi;

   modport source (output valid, row0_lo, row0_hi, row1_lo, row1_hi,
                   row2_lo, row2_hi, row3_lo, row3_hi, input ready);
   modport sink   (input valid, row0_lo, row0_hi, row1_lo, row1_hi,
                   row2_lo, row2_hi, row3_lo, row3_hi, output ready);
endinterface

interface knot_rsp_if import knot_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] out_row0_lo;
   logic [HALF_W-1:0] out_row0_hi;
   logic [HALF_W-1:0] out_row1_lo;
   logic [HALF_W-1:0] out_row1_hi;
   logic [HALF_W-1:0] out_row2_lo;
   logic [HALF_W-1:0] out_row2_hi;
   logic [HALF_W-1:0] out_row3_lo;
   logic [HALF_W-1:0] out_row3_hi;

   modport source (output valid, out_row0_lo, out_row0_hi, out_row1_lo, out_row1_hi,
                   out_row2_lo, out_row2_hi, out_row3_lo, out_row3_hi, input ready);
   modport sink   (input valid, out_row0_lo, out_row0_hi, out_row1_lo, out_row1_hi,
                   out_row2_lo, out_row2_hi, out_row3_lo, out_row3_hi, output ready);
endinterface

/* hw/rtl/knot_permutation_top.sv */
// KNOT-256/384/512 permutation, one round per cycle through a shared round unit.
// The round count is round_count clamped to 52, 104 or 140 by the variant
//   (zero rounds: no round step, the loaded state is the result).
// A new request is taken only once the previous response has been accepted.
// Reset (synchronous, active high): variant 0, round_count 52, sequencer idle.
module knot_permutation_top import knot_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   knot_req_if.sink             req_chan,
   knot_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   // Configuration registers; variant codes above the last one act as the last.
   variant_type        variant_ff;
   logic [ROUND_W-1:0] rounds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= VAR_256_RC6;
         rounds_ff  <= LEN_RC6;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VARIANT: begin
               if (csr_wdata[VAR_W-1:0] > VAR_512_RC8) begin
                  variant_ff <= VAR_512_RC8;
               end else begin
                  variant_ff <= variant_type'(csr_wdata[VAR_W-1:0]);
               end
            end
            CSR_ROUNDS: rounds_ff <= csr_wdata[ROUND_W-1:0];
            default: ;  // unknown index: write dropped
         endcase
      end
   end

   // Sequencer
   ctrl_type        ctrl;
   logic [RC_W-1:0] rc;

   knot_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .variant     (variant_ff),
      .round_count (rounds_ff),
      .ctrl        (ctrl),
      .rc          (rc)
   );

   // State rows; loaded masked to the state width, then updated once per round.
   row_type row_ff [4];
   row_type row_in [4];
   row_type row_nx [4];
   row_type mask;

   knot_round u_round (
      .variant (variant_ff),
      .rc      (rc),
      .row_in  (row_ff),
      .row_out (row_nx)
   );

   always_comb begin
      mask = row_mask(variant_ff);
      row_in = row_ff;
      if (ctrl.load) begin
         row_in[0] = {req_chan.row0_hi, req_chan.row0_lo} & mask;
         row_in[1] = {req_chan.row1_hi, req_chan.row1_lo} & mask;
         row_in[2] = {req_chan.row2_hi, req_chan.row2_lo} & mask;
         row_in[3] = {req_chan.row3_hi, req_chan.row3_lo} & mask;
      end else if (ctrl.step) begin
         row_in = row_nx;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   // Handshake and result; rows stay masked, so unused high bits read zero.
   assign req_chan.ready       = ctrl.ready;
   assign rsp_chan.valid       = ctrl.rsp_valid;
   assign rsp_chan.out_row0_lo = row_ff[0][HALF_W-1:0];
   assign rsp_chan.out_row0_hi = row_ff[0][ROW_W-1:HALF_W];
   assign rsp_chan.out_row1_lo = row_ff[1][HALF_W-1:0];
   assign rsp_chan.out_row1_hi = row_ff[1][ROW_W-1:HALF_W];
   assign rsp_chan.out_row2_lo = row_ff[2][HALF_W-1:0];
   assign rsp_chan.out_row2_hi = row_ff[2][ROW_W-1:HALF_W];
   assign rsp_chan.out_row3_lo = row_ff[3][HALF_W-1:0];
   assign rsp_chan.out_row3_hi = row_ff[3][ROW_W-1:HALF_W];

endmodule

/* hw/rtl/knot_round.sv */
// One KNOT round: constant add, bit-sliced S-box, row rotations.
// Shared by every round of a request. Depends on knot_pkg.
module knot_round import knot_pkg::*; (
   input  variant_type     variant,
   input  logic [RC_W-1:0] rc,
   input  row_type         row_in  [4],
   output row_type         row_out [4]
);

   function automatic row_type rol64(row_type x, int r);
      logic [127:0] d;
      d = {x[63:0], x[63:0]} << r;
      return {{(ROW_W-64){1'b0}}, d[127:64]};
   endfunction

   function automatic row_type rol96(row_type x, int r);
      logic [191:0] d;
      d = {x[95:0], x[95:0]} << r;
      return {{(ROW_W-96){1'b0}}, d[191:96]};
   endfunction

   function automatic row_type rol128(row_type x, int r);
      logic [255:0] d;
      d = {x, x} << r;
      return d[255:128];
   endfunction

   row_type mask;
   row_type a0, a1, a2, a3;
   row_type t1, t3, t6, u;
   row_type b1, b2, b3;

   always_comb begin
      mask = row_mask(variant);
      a0   = row_in[0] ^ {{(ROW_W-RC_W){1'b0}}, rc};
      a1   = row_in[1];
      a2   = row_in[2];
      a3   = row_in[3];
      t1   = ~a0;
      t3   = a2 ^ (a1 & t1);
      b3   = (a3 ^ t3) & mask;
      t6   = a3 ^ t1;
      b2   = ((a1 | a2) ^ t6) & mask;
      u    = a1 ^ a3;
      b1   = (t3 ^ (b2 & u)) & mask;
      row_out[0] = (u ^ (t3 & t6)) & mask;
      unique case (variant)
         VAR_256_RC6, VAR_256_RC7: begin
            row_out[1] = rol64(b1, 1);
            row_out[2] = rol64(b2, 8);
            row_out[3] = rol64(b3, 25);
         end
         VAR_384_RC7: begin
            row_out[1] = rol96(b1, 1);
            row_out[2] = rol96(b2, 8);
            row_out[3] = rol96(b3, 55);
         end
         default: begin
            row_out[1] = rol128(b1, 1);
            row_out[2] = rol128(b2, 16);
            row_out[3] = rol128(b3, 25);
         end
      endcase
   end

endmodule

/* hw/rtl/knot_ctrl.sv */
// Round sequencer: handshake FSM, round counter and round-constant LFSR.
// Depends on knot_pkg.
module knot_ctrl import knot_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               rsp_ready,
   input  variant_type        variant,
   input  logic [ROUND_W-1:0] round_count,
   output ctrl_type           ctrl,
   output logic [RC_W-1:0]    rc
);

   fsm_type            state_ff, state_in;
   logic [ROUND_W-1:0] left_ff, left_in;
   logic [RC_W-1:0]    rc_ff, rc_in;
   logic [ROUND_W-1:0] len;
   logic [ROUND_W-1:0] rounds;
   logic               fb;

   // clamp round count to the table length
   always_comb begin
      unique case (variant)
         VAR_256_RC6: len = LEN_RC6;
         VAR_512_RC8: len = LEN_RC8;
         default:     len = LEN_RC7;
      endcase
      rounds = (round_count > len) ? len : round_count;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (rounds == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (left_ff == ROUND_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.ready = 1'b1;
            ctrl.load  = req_valid;
         end
         ST_RUN:  ctrl.step      = 1'b1;
         ST_DONE: ctrl.rsp_valid = 1'b1;
         default: ctrl = '0;
      endcase
   end

   // LFSR feedback per constant width
   always_comb begin
      unique case (variant)
         VAR_256_RC6: fb = rc_ff[5] ^ rc_ff[4];
         VAR_512_RC8: fb = rc_ff[7] ^ rc_ff[5] ^ rc_ff[4] ^ rc_ff[3];
         default:     fb = rc_ff[6] ^ rc_ff[5];
      endcase
   end

   always_comb begin
      left_in = left_ff;
      rc_in   = rc_ff;
      if (ctrl.load) begin
         left_in = rounds;
         rc_in   = RC_SEED;
      end else if (ctrl.step) begin
         left_in = left_ff - ROUND_W'(1);
         rc_in   = {rc_ff[RC_W-2:0], fb};
         unique case (variant)
            VAR_256_RC6: rc_in[7:6] = 2'b00;
            VAR_512_RC8: rc_in[7]   = rc_ff[6];
            default:     rc_in[7]   = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         left_ff  <= '0;
         rc_ff    <= RC_SEED;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
         rc_ff    <= rc_in;
      end
   end

   assign rc = rc_ff;

endmodule

/* bench/knot_permutation_check.sv */
`timescale 1ns / 100ps
// Scoreboard for the KNOT permutation block: watches both channels and the register port.
// Predicts each permuted state and compares it with the response. Depends on knot_pkg, knot_if.
module knot_permutation_check import knot_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   knot_req_if                  req_chan,
   knot_rsp_if                  rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output int                   checked_count,
   output int                   mismatch_count,
   output int                   pending_count
);

   typedef logic [3:0][ROW_W-1:0] state_type;

   localparam int REPORT_LIMIT = 30;

   logic [VAR_W-1:0]   cfg_variant;
   logic [ROUND_W-1:0] cfg_rounds;
   state_type          expected_states [$];
   int                 report_count;

   // Full permutation of one state under the given register values.
   function automatic state_type permute(input state_type          in_rows,
                                         input logic [VAR_W-1:0]   var_sel,
                                         input logic [ROUND_W-1:0] rounds);
      variant_type     v;
      row_type         m, a0, a1, a2, a3, b1, b2, b3, t1, t3, t6;
      int              w, rot2, rot3, rc_bits, n, k;
      logic [RC_W-1:0] rc;
      state_type       s;
      v = (var_sel > 3'd4) ? VAR_512_RC8 : variant_type'(var_sel);
      case (v)
         VAR_256_RC6: begin
            w = 64;  rot2 = 8;  rot3 = 25; rc_bits = 6; n = int'(LEN_RC6);
         end
         VAR_256_RC7: begin
            w = 64;  rot2 = 8;  rot3 = 25; rc_bits = 7; n = int'(LEN_RC7);
         end
         VAR_384_RC7: begin
            w = 96;  rot2 = 8;  rot3 = 55; rc_bits = 7; n = int'(LEN_RC7);
         end
         VAR_512_RC7: begin
            w = 128; rot2 = 16; rot3 = 25; rc_bits = 7; n = int'(LEN_RC7);
         end
         default: begin
            w = 128; rot2 = 16; rot3 = 25; rc_bits = 8; n = int'(LEN_RC8);
         end
      endcase
      if (int'(rounds) < n) n = int'(rounds);
      m = (w == ROW_W) ? '1 : ((row_type'(1) << w) - row_type'(1));
      for (k = 0; k < 4; k++) s[k] = in_rows[k] & m;
      rc = RC_SEED;
      repeat (n) begin
         s[0] = s[0] ^ row_type'(rc);
         a0 = s[0]; a1 = s[1]; a2 = s[2]; a3 = s[3];
         // bit-sliced S-box on every column
         t1 = ~a0;
         t3 = a2 ^ (a1 & t1);
         b3 = a3 ^ t3;
         t6 = a3 ^ t1;
         b2 = (a1 | a2) ^ t6;
         t1 = a1 ^ a3;
         a0 = t1 ^ (t3 & t6);
         b1 = t3 ^ (b2 & t1);
         b1 = b1 & m; b2 = b2 & m; b3 = b3 & m;
         s[0] = a0 & m;
         s[1] = ((b1 << 1) | (b1 >> (w - 1))) & m;
         s[2] = ((b2 << rot2) | (b2 >> (w - rot2))) & m;
         s[3] = ((b3 << rot3) | (b3 >> (w - rot3))) & m;
         // LFSR for the next round constant
         case (rc_bits)
            6:       rc = {2'b00, rc[4:0], rc[5] ^ rc[4]};
            7:       rc = {1'b0, rc[5:0], rc[6] ^ rc[5]};
            default: rc = {rc[6:0], rc[7] ^ rc[5] ^ rc[4] ^ rc[3]};
         endcase
      end
      return s;
   endfunction

   always @(posedge clock) begin
      state_type incoming, observed, predicted;
      logic      bad;
      int        k, h;
      if (reset) begin
         cfg_variant    = VAR_256_RC6;
         cfg_rounds     = LEN_RC6;
         expected_states.delete();
         report_count   = 0;
         checked_count  <= 0;
         mismatch_count <= 0;
         pending_count  <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_VARIANT: cfg_variant = csr_wdata[VAR_W-1:0];
               CSR_ROUNDS:  cfg_rounds  = csr_wdata[ROUND_W-1:0];
               default:     ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            incoming[0] = {req_chan.row0_hi, req_chan.row0_lo};
            incoming[1] = {req_chan.row1_hi, req_chan.row1_lo};
            incoming[2] = {req_chan.row2_hi, req_chan.row2_lo};
            incoming[3] = {req_chan.row3_hi, req_chan.row3_lo};
            expected_states.push_back(permute(incoming, cfg_variant, cfg_rounds));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            observed[0] = {rsp_chan.out_row0_hi, rsp_chan.out_row0_lo};
            observed[1] = {rsp_chan.out_row1_hi, rsp_chan.out_row1_lo};
            observed[2] = {rsp_chan.out_row2_hi, rsp_chan.out_row2_lo};
            observed[3] = {rsp_chan.out_row3_hi, rsp_chan.out_row3_lo};
            if (expected_states.size() == 0) begin
               if (report_count < REPORT_LIMIT)
                  $display("%0t: response with none expected, got %h", $time, observed);
               report_count++;
               mismatch_count <= mismatch_count + 1;
            end else begin
               predicted = expected_states.pop_front();
               bad = 1'b0;
               for (k = 0; k < 4; k++) begin
                  for (h = 0; h < 2; h++) begin
                     if (predicted[k][h*HALF_W +: HALF_W] !== observed[k][h*HALF_W +: HALF_W]) begin
                        bad = 1'b1;
                        if (report_count < REPORT_LIMIT)
                           $display("%0t: out_row%0d_%s mismatch, expected %h, got %h",
                                    $time, k, h ? "hi" : "lo",
                                    predicted[k][h*HALF_W +: HALF_W],
                                    observed[k][h*HALF_W +: HALF_W]);
                     end
                  end
               end
               if (bad) begin
                  report_count++;
                  mismatch_count <= mismatch_count + 1;
               end
               checked_count <= checked_count + 1;
            end
         end
         pending_count <= expected_states.size();
      end
   end

endmodule

/* bench/knot_permutation_top_tb.sv */
`timescale 1ns / 100ps
// Top of the KNOT permutation bench: clock, reset, request and register stimulus, verdict.
// Instantiates knot_permutation_top and knot_permutation_check; needs knot_pkg and knot_if.
module knot_permutation_top_tb;
   import knot_pkg::*;

   typedef logic [7:0][HALF_W-1:0] req_words_type;   // row0_lo, row0_hi, ... row3_hi

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam int            RANDOM_REQUESTS = 1900;
   localparam int            TAIL_CYCLES     = LEN_RC8 + 10;   // longest latency plus margin
   localparam int            PRESSURE_HOLD   = 600;            // receiver hold-off, in cycles
   localparam logic [HALF_W-1:0] ALT_WORD    = 64'ha5a5_5a5a_f0f0_0f0f;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   int   checked_count, mismatch_count, pending_count;
   int   sent_count;
   int   setting_count;
   int   directed_count;
   bit   steady;        // no idling on either side while set
   bit   hold_armed;    // asks the receiver for one long hold-off
   bit   hold_done;     // set once the receiver has run its hold-off

   knot_req_if req_chan ();
   knot_rsp_if rsp_chan ();

   knot_permutation_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   knot_permutation_check i_check (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .checked_count  (checked_count),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #2 clock = ~clock;

   // Idle length for either side: mostly none, some short, a few long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (steady || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random state words; whole words of zeros or ones now and then.
   function automatic req_words_type random_words();
      req_words_type words;
      int            roll, k;
      for (k = 0; k < 8; k++) begin
         roll = $urandom_range(9);
         if (roll == 0)      words[k] = '0;
         else if (roll == 1) words[k] = '1;
         else                words[k] = {$urandom, $urandom};
      end
      return words;
   endfunction

   // Offer one request and wait for the handshake; valid stays high if the
   // next request follows with no gap.
   task automatic send_request(input req_words_type words);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.row0_lo <= words[0];
      req_chan.row0_hi <= words[1];
      req_chan.row1_lo <= words[2];
      req_chan.row1_hi <= words[3];
      req_chan.row2_lo <= words[4];
      req_chan.row2_hi <= words[5];
      req_chan.row3_lo <= words[6];
      req_chan.row3_hi <= words[7];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   // Drop valid and wait until every request has its response checked.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (checked_count < sent_count) @(posedge clock);
   endtask

   // One register write; the caller lowers csr_we after its last write.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DAT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [CSR_DAT_W-1:0] variant_data,
                               input logic [CSR_DAT_W-1:0] round_data);
      csr_write(CSR_VARIANT, variant_data);
      csr_write(CSR_ROUNDS, round_data);
      csr_we <= 1'b0;
      setting_count++;
   endtask

   // Response side: ready with random gaps, plus one long hold-off on request
   // so the block fills up and back-pressures the request channel.
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      hold_done      = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         if (hold_armed && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (PRESSURE_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // Request side and verdict.
   initial begin
      logic [CSR_DAT_W-1:0] var_data, round_data;
      int                   roll, batch, phase, random_sent;
      req_chan.valid   = 1'b0;
      req_chan.row0_lo = '0;
      req_chan.row0_hi = '0;
      req_chan.row1_lo = '0;
      req_chan.row1_hi = '0;
      req_chan.row2_lo = '0;
      req_chan.row2_hi = '0;
      req_chan.row3_lo = '0;
      req_chan.row3_hi = '0;
      csr_we           = 1'b0;
      csr_index        = CSR_VARIANT;
      csr_wdata        = '0;
      steady           = 1'b0;
      hold_armed       = 1'b0;
      sent_count       = 0;
      setting_count    = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // reset values: 256-bit state, 6-bit constants, 52 rounds
      send_request('0);
      send_request('1);
      drain();
      // zero rounds: output is each input row cut to 64 bits
      program_regs(CSR_DAT_W'(VAR_256_RC6), 8'd0);
      send_request('1);
      send_request({8{ALT_WORD}});
      drain();
      program_regs(CSR_DAT_W'(VAR_256_RC7), LEN_RC7);
      send_request('0);
      send_request('1);
      drain();
      // round count far beyond the table: clamped to 104
      program_regs(CSR_DAT_W'(VAR_384_RC7), 8'hff);
      send_request('1);
      send_request({8{ALT_WORD}});
      drain();
      program_regs(CSR_DAT_W'(VAR_512_RC7), 8'd1);
      send_request('1);
      drain();
      program_regs(CSR_DAT_W'(VAR_512_RC8), LEN_RC8);
      send_request('0);
      send_request('1);
      drain();
      program_regs(CSR_DAT_W'(VAR_512_RC8), 8'd200);
      send_request({8{ALT_WORD}});
      drain();
      // variant codes past the last one behave as the 512-bit, 8-bit set
      program_regs(8'd7, LEN_RC8);
      send_request('1);
      drain();
      program_regs(8'd5, 8'd0);
      send_request('1);
      drain();
      // zero rounds at 384 bits: upper 32 bits of each high half cleared
      program_regs(CSR_DAT_W'(VAR_384_RC7), 8'd0);
      send_request({8{ALT_WORD}});
      send_request('1);
      drain();
      program_regs(CSR_DAT_W'(VAR_256_RC6), LEN_RC6 + 8'd1);
      send_request('1);
      drain();
      // writes to indexes with no register must leave the settings alone
      csr_write(CSR_VARIANT, CSR_DAT_W'(VAR_384_RC7));
      csr_write(CSR_ROUNDS, 8'd20);
      csr_write(CSR_SPARE_A, 8'hff);
      csr_write(CSR_SPARE_B, 8'h00);
      csr_we <= 1'b0;
      setting_count++;
      send_request('1);
      drain();
      // upper data bits of the variant write are dropped: 0xfe selects code 6
      program_regs(8'hfe, 8'hff);
      send_request('1);
      drain();
      directed_count = sent_count;

      // ---- random part: phases of one setting each ----
      phase       = 0;
      random_sent = 0;
      while (random_sent < RANDOM_REQUESTS) begin
         roll = $urandom_range(99);
         if (roll < 85) var_data = CSR_DAT_W'($urandom_range(4));
         else           var_data = CSR_DAT_W'($urandom_range(255));
         roll = $urandom_range(99);
         if (roll < 8)       round_data = 8'd0;
         else if (roll < 12) round_data = 8'd1;
         else if (roll < 20) begin
            case ($urandom_range(2))
               0:       round_data = LEN_RC6;
               1:       round_data = LEN_RC7;
               default: round_data = LEN_RC8;
            endcase
         end
         else if (roll < 28) round_data = CSR_DAT_W'($urandom_range(255));
         else                round_data = CSR_DAT_W'($urandom_range(2, 48));
         steady = ($urandom_range(9) == 0);
         batch  = $urandom_range(10, 60);
         // one phase with the response side held off for a long stretch
         if (phase == 3) begin
            steady     = 1'b1;
            hold_armed = 1'b1;
         end
         program_regs(var_data, round_data);
         repeat (batch) send_request(random_words());
         drain();
         random_sent += batch;
         phase++;
      end
      steady = 1'b0;

      // let any stray response show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Ran %0d directed and %0d random permutation requests under %0d register settings,",
               directed_count, sent_count - directed_count, setting_count);
      $display("%0d responses checked, %0d bad, %0d still expected.",
               checked_count, mismatch_count, pending_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
